FILE: hdl/ovn_pkg.sv
// Shared types, constants and arithmetic helpers for the octave value noise block.
package ovn_pkg;

   localparam int COORD_W     = 32;
   localparam int INDEX_W     = 12;
   localparam int VALUE_W     = 16;
   localparam int NOISE_W     = 18;
   localparam int CFG_W       = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int OCTAVE_W    = 4;
   localparam int AMP_W       = 16;
   localparam int ROM_BITS    = 8;
   localparam int ROM_SIZE    = 1 << ROM_BITS;
   localparam int Y_SHIFT     = 4;
   localparam int Z_SHIFT     = 8;
   localparam int ONE_Q16     = 65536;
   localparam int NOISE_MAX   = 262143;

   localparam logic [AMP_W-1:0]    AMP_START      = 16'd32768;
   localparam logic [CFG_W-1:0]    FALLOFF_RESET  = 17'd32768;
   localparam logic [OCTAVE_W-1:0] OCTAVES_RESET  = 4'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OCTAVE_COUNT = 2'd0,
      CSR_FALLOFF      = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                 valid;
      logic                 query;
      logic [INDEX_W-1:0]   table_index;
      logic [VALUE_W-1:0]   table_value;
      logic [COORD_W-1:0]   mag_x;
      logic [COORD_W-1:0]   mag_y;
      logic [COORD_W-1:0]   mag_z;
   } ovn_item_type;

   typedef logic [VALUE_W-1:0] smooth_rom_type [ROM_SIZE];

   // (1 - cos(pi*k/256)) / 2 in Q0.16, series evaluated in Q30
   function automatic logic [VALUE_W-1:0] smooth_low_half(input int unsigned k);
      logic [63:0]        theta;
      logic [63:0]        t2;
      logic [63:0]        term;
      logic signed [63:0] c;
      logic signed [63:0] omc;
      logic [63:0]        r;
      theta = (64'd3373259426 * 64'(k)) >> ROM_BITS;
      t2    = (theta * theta) >> 30;
      term  = 64'd1 << 30;
      c     = 64'sd1 <<< 30;
      for (int n = 1; n <= 7; n++) begin
         term = (term * t2) >> 30;
         case (n)
            1:       term = term / 2;
            2:       term = term / 12;
            3:       term = term / 30;
            4:       term = term / 56;
            5:       term = term / 90;
            6:       term = term / 132;
            default: term = term / 182;
         endcase
         if (n[0])
            c = c - $signed(term);
         else
            c = c + $signed(term);
      end
      omc = (64'sd1 <<< 30) - c;
      if (omc < 0)
         omc = 0;
      if (omc > (64'sd1 <<< 31))
         omc = 64'sd1 <<< 31;
      r = ((64'(omc) << 16) + (64'd1 << 30)) >> 31;
      return r[VALUE_W-1:0];
   endfunction

   function automatic smooth_rom_type build_smooth_rom();
      smooth_rom_type rom;
      for (int k = 0; k <= ROM_SIZE / 2; k++)
         rom[k] = smooth_low_half(k);
      for (int k = ROM_SIZE / 2 + 1; k < ROM_SIZE; k++)
         rom[k] = 16'(17'(ONE_Q16) - 17'(rom[ROM_SIZE - k]));
      return rom;
   endfunction

   localparam smooth_rom_type SMOOTH_ROM = build_smooth_rom();

   // (a*(1-w) + b*w) rounded, all Q0.16
   function automatic logic [VALUE_W-1:0] blend(input logic [VALUE_W-1:0] a,
                                                input logic [VALUE_W-1:0] b,
                                                input logic [VALUE_W-1:0] w);
      logic [16:0] wn;
      logic [33:0] s;
      wn = 17'(ONE_Q16) - {1'b0, w};
      s  = 34'(a) * 34'(wn) + 34'(b) * 34'(w) + 34'd32768;
      return s[31:16];
   endfunction

endpackage

FILE: hdl/ovn_if.sv
// Request and response channel interfaces of the octave value noise block.
interface ovn_req_if;
   import ovn_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [INDEX_W-1:0]        table_index;
   logic [VALUE_W-1:0]        table_value;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;
   logic signed [COORD_W-1:0] coord_z;

   modport source (output valid, req_type, table_index, table_value, coord_x, coord_y,
                   coord_z, input ready);
   modport sink (input valid, req_type, table_index, table_value, coord_x, coord_y,
                 coord_z, output ready);
endinterface

interface ovn_rsp_if;
   import ovn_pkg::*;
   logic               valid;
   logic               ready;
   logic [NOISE_W-1:0] noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

FILE: hdl/ovn_ram.sv
// Generic RAM: one write port, two registered read ports.
module ovn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

FILE: hdl/ovn_octave.sv
// One octave: corner lookup, trilinear blend and amplitude-weighted accumulate.
module ovn_octave #(
   parameter int OCTAVE     = 0,
   parameter int TABLE_BITS = 12,
   parameter int FRAC_BITS  = 16,
   parameter int SUM_W      = 35
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        active,
   input  logic [ovn_pkg::AMP_W-1:0]   amp,
   input  ovn_pkg::ovn_item_type       item_in,
   input  logic [SUM_W-1:0]            sum_in,
   output ovn_pkg::ovn_item_type       item_out,
   output logic [SUM_W-1:0]            sum_out
);
   import ovn_pkg::*;

   localparam int PW    = COORD_W + OCTAVE + TABLE_BITS;
   localparam int DEPTH = 1 << TABLE_BITS;

   logic [PW-1:0]         px;
   logic [PW-1:0]         py;
   logic [PW-1:0]         pz;
   logic [TABLE_BITS-1:0] ix;
   logic [TABLE_BITS-1:0] iy;
   logic [TABLE_BITS-1:0] iz;
   logic [TABLE_BITS-1:0] base;
   logic [TABLE_BITS-1:0] addr [8];
   logic [VALUE_W-1:0]    corner [8];
   logic [VALUE_W-1:0]    wx;
   logic [VALUE_W-1:0]    wy;
   logic [VALUE_W-1:0]    wz;
   logic                  wr_en;

   // stage 1: weights, table data arrives from the RAMs
   ovn_item_type       s1_item_ff;
   logic [SUM_W-1:0]   s1_sum_ff;
   logic [VALUE_W-1:0] s1_wx_ff, s1_wy_ff, s1_wz_ff;
   // stage 2: x blends
   ovn_item_type       s2_item_ff;
   logic [SUM_W-1:0]   s2_sum_ff;
   logic [VALUE_W-1:0] s2_wy_ff, s2_wz_ff;
   logic [VALUE_W-1:0] s2_xb_ff [4];
   // stage 3: y blends
   ovn_item_type       s3_item_ff;
   logic [SUM_W-1:0]   s3_sum_ff;
   logic [VALUE_W-1:0] s3_wz_ff;
   logic [VALUE_W-1:0] s3_yb_ff [2];
   // stage 4: z blend
   ovn_item_type       s4_item_ff;
   logic [SUM_W-1:0]   s4_sum_ff;
   logic [VALUE_W-1:0] s4_zb_ff;
   // stage 5: weighted product
   ovn_item_type       s5_item_ff;
   logic [SUM_W-1:0]   s5_sum_ff;
   logic [31:0]        s5_prod_ff;

   assign px = PW'(item_in.mag_x) << OCTAVE;
   assign py = PW'(item_in.mag_y) << OCTAVE;
   assign pz = PW'(item_in.mag_z) << OCTAVE;
   assign ix = px[FRAC_BITS +: TABLE_BITS];
   assign iy = py[FRAC_BITS +: TABLE_BITS];
   assign iz = pz[FRAC_BITS +: TABLE_BITS];
   assign base = ix + (iy << Y_SHIFT) + (iz << Z_SHIFT);

   assign wx = SMOOTH_ROM[px[FRAC_BITS-1 -: ROM_BITS]];
   assign wy = SMOOTH_ROM[py[FRAC_BITS-1 -: ROM_BITS]];
   assign wz = SMOOTH_ROM[pz[FRAC_BITS-1 -: ROM_BITS]];

   // writes take effect here, in request order with the queries around them
   assign wr_en = advance && item_in.valid && !item_in.query;

   for (genvar k = 0; k < 8; k++) begin : g_addr
      localparam int OFF = (k % 2) + ((k / 2) % 2) * (1 << Y_SHIFT)
                         + ((k / 4) % 2) * (1 << Z_SHIFT);
      assign addr[k] = base + TABLE_BITS'(OFF);
   end

   for (genvar r = 0; r < 4; r++) begin : g_ram
      ovn_ram #(
         .WIDTH (VALUE_W),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock     (clock),
         .wr_en     (wr_en),
         .wr_addr   (TABLE_BITS'(item_in.table_index)),
         .wr_data   (item_in.table_value),
         .rd_en     (advance),
         .rd_addr_a (addr[2*r]),
         .rd_addr_b (addr[2*r+1]),
         .rd_data_a (corner[2*r]),
         .rd_data_b (corner[2*r+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_item_ff.valid <= 1'b0;
         s2_item_ff.valid <= 1'b0;
         s3_item_ff.valid <= 1'b0;
         s4_item_ff.valid <= 1'b0;
         s5_item_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_item_ff <= item_in;
         s2_item_ff <= s1_item_ff;
         s3_item_ff <= s2_item_ff;
         s4_item_ff <= s3_item_ff;
         s5_item_ff <= s4_item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sum_ff <= sum_in;
         s1_wx_ff  <= wx;
         s1_wy_ff  <= wy;
         s1_wz_ff  <= wz;

         s2_sum_ff <= s1_sum_ff;
         s2_wy_ff  <= s1_wy_ff;
         s2_wz_ff  <= s1_wz_ff;
         for (int i = 0; i < 4; i++)
            s2_xb_ff[i] <= blend(corner[2*i], corner[2*i+1], s1_wx_ff);

         s3_sum_ff   <= s2_sum_ff;
         s3_wz_ff    <= s2_wz_ff;
         s3_yb_ff[0] <= blend(s2_xb_ff[0], s2_xb_ff[1], s2_wy_ff);
         s3_yb_ff[1] <= blend(s2_xb_ff[2], s2_xb_ff[3], s2_wy_ff);

         s4_sum_ff <= s3_sum_ff;
         s4_zb_ff  <= blend(s3_yb_ff[0], s3_yb_ff[1], s3_wz_ff);

         s5_sum_ff  <= s4_sum_ff;
         s5_prod_ff <= 32'(s4_zb_ff) * 32'(amp);
      end
   end

   assign item_out = s5_item_ff;
   assign sum_out  = s5_sum_ff + ((active && s5_item_ff.query) ? SUM_W'(s5_prod_ff) : '0);

endmodule

FILE: hdl/octave_value_noise_3d_top.sv
// Top level of the octave value noise block: config registers, octave chain, output stage.
//
// Takes one request per cycle unless the output stalls and returns one noise value per
// query request, in order, through the input register, five stages per octave and the
// output register. Each octave stage owns four dual-read copies of the noise table so
// all eight lattice corners are read in parallel; a table write travels down the same
// pipeline and updates each octave's copies as it passes, so writes and queries see the
// table in request order. The table has no reset and needs no clearing. A response that
// is not taken stalls the whole pipeline; nothing is dropped. Unused octaves (beyond
// octave_count) still take their pipeline slots and add zero.
module octave_value_noise_3d_top #(
   parameter int TABLE_BITS  = 12,
   parameter int MAX_OCTAVES = 8,
   parameter int FRAC_BITS   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   ovn_req_if.sink                          req_chan,
   ovn_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [ovn_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ovn_pkg::CFG_W-1:0]        csr_wdata
);
   import ovn_pkg::*;

   localparam int OW    = $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W = 32 + $clog2(MAX_OCTAVES);

   logic [OW-1:0]      octave_count_ff, octave_count_in;
   logic [CFG_W-1:0]   falloff_ff, falloff_in;
   logic [CFG_W-1:0]   falloff_clip;
   logic               advance;
   ovn_item_type       in_item_ff, in_item_in;
   ovn_item_type       item [MAX_OCTAVES+1];
   logic [SUM_W-1:0]   sum [MAX_OCTAVES+1];
   logic [AMP_W-1:0]   amp [MAX_OCTAVES];
   logic [SUM_W:0]     rounded;
   logic [SUM_W-16:0]  rounded_q;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NOISE_W-1:0] noise_ff, noise_in;

   // configuration writes
   always_comb begin
      octave_count_in = octave_count_ff;
      falloff_in      = falloff_ff;
      falloff_clip    = (csr_wdata > CFG_W'(ONE_Q16)) ? CFG_W'(ONE_Q16) : csr_wdata;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OCTAVE_COUNT: begin
               if (int'(csr_wdata[OCTAVE_W-1:0]) > MAX_OCTAVES)
                  octave_count_in = OW'(MAX_OCTAVES);
               else if (csr_wdata[OCTAVE_W-1:0] != '0)
                  octave_count_in = OW'(csr_wdata[OCTAVE_W-1:0]);
            end
            CSR_FALLOFF: begin
               if (falloff_clip != '0)
                  falloff_in = falloff_clip;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= (int'(OCTAVES_RESET) > MAX_OCTAVES) ? OW'(MAX_OCTAVES)
                                                                : OW'(OCTAVES_RESET);
         falloff_ff      <= FALLOFF_RESET;
      end else begin
         octave_count_ff <= octave_count_in;
         falloff_ff      <= falloff_in;
      end
   end

   // amplitude per octave, each registered from the previous octave's amplitude times the falloff
   assign amp[0] = AMP_START;
   for (genvar o = 1; o < MAX_OCTAVES; o++) begin : g_amp
      logic [AMP_W-1:0] amp_ff;
      logic [33:0]      amp_prod;
      assign amp_prod = 34'(amp[o-1]) * 34'(falloff_ff) + 34'd32768;
      always_ff @(posedge clock) begin
         amp_ff <= amp_prod[16 +: AMP_W];
      end
      assign amp[o] = amp_ff;
   end

   // pipeline moves whenever the output register is free or being emptied
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      in_item_in.valid       = req_chan.valid;
      in_item_in.query       = req_chan.req_type;
      in_item_in.table_index = req_chan.table_index;
      in_item_in.table_value = req_chan.table_value;
      in_item_in.mag_x = req_chan.coord_x[COORD_W-1] ? COORD_W'(-req_chan.coord_x)
                                                      : COORD_W'(req_chan.coord_x);
      in_item_in.mag_y = req_chan.coord_y[COORD_W-1] ? COORD_W'(-req_chan.coord_y)
                                                      : COORD_W'(req_chan.coord_y);
      in_item_in.mag_z = req_chan.coord_z[COORD_W-1] ? COORD_W'(-req_chan.coord_z)
                                                      : COORD_W'(req_chan.coord_z);
   end

   always_ff @(posedge clock) begin
      if (reset)
         in_item_ff.valid <= 1'b0;
      else if (advance)
         in_item_ff <= in_item_in;
   end

   assign item[0] = in_item_ff;
   assign sum[0]  = '0;

   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
      ovn_octave #(
         .OCTAVE     (o),
         .TABLE_BITS (TABLE_BITS),
         .FRAC_BITS  (FRAC_BITS),
         .SUM_W      (SUM_W)
      ) u_octave (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .active   (int'(octave_count_ff) > o),
         .amp      (amp[o]),
         .item_in  (item[o]),
         .sum_in   (sum[o]),
         .item_out (item[o+1]),
         .sum_out  (sum[o+1])
      );
   end

   // round to Q2.16 and saturate
   assign rounded   = (SUM_W+1)'(sum[MAX_OCTAVES]) + (SUM_W+1)'(32768);
   assign rounded_q = rounded[SUM_W:16];
   assign noise_in  = (64'(rounded_q) > 64'(NOISE_MAX)) ? NOISE_W'(NOISE_MAX)
                                                        : NOISE_W'(rounded_q);
   assign rsp_valid_in = item[MAX_OCTAVES].valid && item[MAX_OCTAVES].query;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (advance)
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance)
         noise_ff <= noise_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.noise_value = noise_ff;

   a_octave_count_range: assert property (@(posedge clock) disable iff (reset)
      octave_count_ff != '0 && int'(octave_count_ff) <= MAX_OCTAVES)
      else $error("octave count out of range");

   a_falloff_range: assert property (@(posedge clock) disable iff (reset)
      falloff_ff != '0 && falloff_ff <= CFG_W'(ONE_Q16))
      else $error("falloff out of range");

   a_stall_only_on_pending: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_valid_ff)
      else $error("request side stalled without a pending response");

endmodule

FILE: tb/ovn_tb_if.sv
// Request record type shared by the testbench tasks and scoreboard.
package ovn_tb_types;
   typedef struct {
      bit        query;
      bit [11:0] idx;
      bit [15:0] val;
      bit [31:0] x, y, z;
   } ovn_req_type;
endpackage

FILE: tb/tb.sv
// Testbench for octave_value_noise_3d_top: table loads, noise queries, config sweeps.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ovn_pkg::*;
   import ovn_tb_types::*;

   localparam int LIMIT = 5000;
   localparam int FILL  = 1024;
   // coordinate reach that keeps every corner index below FILL for up to eight octaves;
   // the high masks only add whole multiples of the table size to the index
   localparam bit [31:0]   X_HI   = 32'h7000_0000;
   localparam bit [31:0]   Y_HI   = 32'h7f00_0000;
   localparam bit [31:0]   Z_HI   = 32'h7ff0_0000;
   localparam int unsigned XY_LIM = 32'h2000;
   localparam int unsigned Z_LIM  = 32'h400;

   class noise_scoreboard;
      bit [15:0] noise_tab [4096];
      bit [3:0]  octaves = 4;
      bit [16:0] falloff = 32768;
      bit [17:0] pending [$];
      int        errors = 0;
      int        checked = 0;

      function bit [31:0] mag(bit [31:0] v);
         return v[31] ? (~v + 1) : v;
      endfunction

      function bit [15:0] mix(bit [15:0] a, bit [15:0] b, bit [15:0] w);
         bit [63:0] s;
         s = 64'(a) * (64'd65536 - w) + 64'(b) * w + 64'd32768;
         return s[31:16];
      endfunction

      function bit [15:0] smooth_w(bit [63:0] p);
         return SMOOTH_ROM[p[15:8]];
      endfunction

      function void note_request(ovn_req_type r);
         bit [63:0] mx, my, mz, px, py, pz, acc;
         bit [31:0] amp;
         bit [11:0] b0, zb;
         bit [15:0] wx, wy, wz, a, c, lo, hi;
         if (!r.query) begin
            noise_tab[r.idx] = r.val;
            return;
         end
         mx = mag(r.x); my = mag(r.y); mz = mag(r.z);
         acc = 0; amp = 32768;
         for (int o = 0; o < octaves; o++) begin
            px = mx << o; py = my << o; pz = mz << o;
            b0 = 12'((px >> 16) + ((py >> 16) << 4) + ((pz >> 16) << 8));
            zb = b0 + 12'd256;
            wx = smooth_w(px); wy = smooth_w(py); wz = smooth_w(pz);
            a  = mix(noise_tab[b0], noise_tab[12'(b0 + 1)], wx);
            c  = mix(noise_tab[12'(b0 + 16)], noise_tab[12'(b0 + 17)], wx);
            lo = mix(a, c, wy);
            a  = mix(noise_tab[zb], noise_tab[12'(zb + 1)], wx);
            c  = mix(noise_tab[12'(zb + 16)], noise_tab[12'(zb + 17)], wx);
            hi = mix(a, c, wy);
            acc += 64'(mix(lo, hi, wz)) * amp;
            amp = 32'((64'(amp) * falloff + 64'd32768) >> 16);
         end
         acc = (acc + 32768) >> 16;
         pending.push_back(acc > NOISE_MAX ? 18'(NOISE_MAX) : acc[17:0]);
      endfunction

      function void check_noise(bit [17:0] got);
         bit [17:0] exp_v;
         if (pending.size() == 0) begin
            $error("unexpected response noise_value=%0d", got);
            errors++;
            return;
         end
         exp_v = pending.pop_front();
         checked++;
         if (exp_v !== got) begin
            $error("noise_value expected %0d actual %0d", exp_v, got);
            errors++;
         end
      endfunction

      function void note_csr(csr_index_type i, bit [16:0] v);
         if (i == CSR_OCTAVE_COUNT) begin
            if (v[3:0] > 8) octaves = 8;
            else if (v[3:0] != 0) octaves = v[3:0];
         end else if (i == CSR_FALLOFF) begin
            if (v > 65536) falloff = 65536;
            else if (v != 0) falloff = v;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_wr_en = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;
   ovn_req_if req_chan();
   ovn_rsp_if rsp_chan();

   octave_value_noise_3d_top u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   noise_scoreboard sb = new();
   int idle_cycles = 0;
   bit stall_on = 1;
   int queries = 0, writes = 0;

   initial begin
      req_chan.valid = 0; req_chan.req_type = 0; req_chan.table_index = 0;
      req_chan.table_value = 0; req_chan.coord_x = 0; req_chan.coord_y = 0;
      req_chan.coord_z = 0; rsp_chan.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset && ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response side: sample before edge updates, random ready gaps
   int rdy_wait = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_noise(rsp_chan.noise_value);
            rdy_wait = stall_on ? $urandom_range(0, 4) : 0;
         end
         if (rdy_wait > 0) begin
            rdy_wait--;
            rsp_chan.ready <= 0;
         end else
            rsp_chan.ready <= 1;
      end
   end

   task automatic send(ovn_req_type r);
      int gap;
      gap = stall_on ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
         @(posedge clock);
         req_chan.valid <= 0;
      end
      @(posedge clock);
      req_chan.valid <= 1;
      req_chan.req_type <= r.query;
      req_chan.table_index <= r.idx;
      req_chan.table_value <= r.val;
      req_chan.coord_x <= r.x;
      req_chan.coord_y <= r.y;
      req_chan.coord_z <= r.z;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(r);
      if (r.query) queries++; else writes++;
      req_chan.valid <= 0;
   endtask

   task automatic write_cell(bit [11:0] i, bit [15:0] v);
      ovn_req_type r;
      r = '{query: 0, idx: i, val: v, x: $urandom, y: $urandom, z: $urandom};
      send(r);
   endtask

   task automatic query(bit [31:0] x, bit [31:0] y, bit [31:0] z);
      ovn_req_type r;
      r = '{query: 1, idx: $urandom, val: $urandom, x: x, y: y, z: z};
      send(r);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (2 + 5 * 8 + 4) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type i, bit [16:0] v);
      @(posedge clock);
      csr_wr_en <= 1; csr_index <= i; csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.note_csr(i, v);
   endtask

   // magnitude is a small part below lim plus optional high bits, then a random sign
   function automatic bit [31:0] safe_coord(bit [31:0] hi_mask, int unsigned lim);
      bit [31:0] m;
      case ($urandom_range(0, 3))
         0: m = 32'h8000_0000;
         1: m = 32'($urandom_range(0, lim - 1));
         2: m = (32'($urandom) & hi_mask) | 32'($urandom_range(0, lim - 1));
         default: m = ($urandom_range(0, 1) != 0) ? 32'(lim - 1) : 32'h0;
      endcase
      return ($urandom_range(0, 1) != 0) ? -m : m;
   endfunction

   task automatic random_phase(int n);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0)
            write_cell($urandom, $urandom);
         else
            query(safe_coord(X_HI, XY_LIM), safe_coord(Y_HI, XY_LIM),
                  safe_coord(Z_HI, Z_LIM));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      // extreme values, then load the low part of the table that all queries stay in
      write_cell(12'd0, 16'hffff);
      write_cell(12'd4095, 16'h0000);
      for (int i = 1; i < FILL; i++) begin
         ovn_req_type r;
         r = '{query: 0, idx: 12'(i), val: 16'($urandom), x: 0, y: 0, z: 0};
         stall_on = (i < 40);
         send(r);
      end
      stall_on = 1;
      // directed queries: zero, most negative, high bits set, fractions
      query(0, 0, 0);
      query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      query(32'h7000_1fff, 32'h8f00_0000, 32'h800f_fc01);
      query(32'hffff_ffff, 32'h0000_1fff, 32'hffff_fc01);
      query(32'h0000_1000, 32'hffff_e001, 32'h0000_0200);
      write_cell(12'd0, 16'hffff);
      query(0, 0, 0);
      drain();
      // sender hold-off until all results are back
      csr_write(CSR_OCTAVE_COUNT, 17'd8);
      csr_write(CSR_FALLOFF, 17'd65536);
      random_phase(60);
      drain();
      csr_write(CSR_OCTAVE_COUNT, 17'd1);
      csr_write(CSR_FALLOFF, 17'd1);
      random_phase(60);
      drain();
      csr_write(CSR_OCTAVE_COUNT, 17'd0);      // ignored
      csr_write(CSR_FALLOFF, 17'd0);           // ignored
      csr_write(CSR_FALLOFF, 17'h1ffff);       // clamps to one
      csr_write(CSR_OCTAVE_COUNT, 17'h1ffff);  // clamps to max
      csr_write(csr_index_type'(2'd3), 17'd5); // unknown index
      random_phase(60);
      drain();
      stall_on = 0;
      csr_write(CSR_OCTAVE_COUNT, 17'd3);
      csr_write(CSR_FALLOFF, 17'd40000);
      random_phase(40);
      stall_on = 1;
      drain();
      for (int p = 0; p < 3; p++) begin
         csr_write(CSR_OCTAVE_COUNT, 17'($urandom_range(1, 8)));
         csr_write(CSR_FALLOFF, 17'($urandom_range(1, 65536)));
         random_phase(20);
         drain();
      end
      $display("Covered %0d table writes and %0d noise queries over several octave/falloff settings.",
               writes, queries);
      $display("%0d responses checked.", sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
